FILE: design/pwm_timer_prescaler_select_assert.svh
// Assertion macros shared by the prescaler-select checker.
`ifndef PWM_TIMER_PRESCALER_SELECT_ASSERT_SVH
`define PWM_TIMER_PRESCALER_SELECT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define PTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pts assertion failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define PTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pts assertion failed");

`endif

FILE: design/pts_pkg.sv
// Types and constants of the PWM prescaler select block.
package pts_pkg;

    localparam int unsigned    DIV_STEPS   = 24;
    localparam int unsigned    PRESC_COUNT = 5;
    localparam logic [23:0]    CLOCK_HZ    = 24'd16000000;
    localparam logic [15:0]    TOP_MAX     = 16'hFFFF;
    localparam logic [23:0]    FIT_MAX     = 24'd65536;
    localparam logic [2:0]     PRESC_LAST  = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_APPLIED   = 2'd0;
    localparam t_status ST_DISABLED  = 2'd1;
    localparam t_status ST_UNCHANGED = 2'd2;
    localparam t_status ST_RANGE     = 2'd3;

    localparam logic CMD_ENABLE = 1'b0;
    localparam logic CMD_RETUNE = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        t_status     status;
        logic [2:0]  prescaler_index;
        logic [15:0] top_value;
        logic [14:0] compare_value;
        logic        compare_written;
        logic        counter_restart;
    } t_result;

    // Prescalers 1, 8, 64, 256, 1024 as right shifts.
    function automatic logic [3:0] presc_shift(input logic [2:0] idx);
        logic [3:0] s;
        case (idx)
            3'd0:    s = 4'd0;
            3'd1:    s = 4'd3;
            3'd2:    s = 4'd6;
            3'd3:    s = 4'd8;
            default: s = 4'd10;
        endcase
        return s;
    endfunction

endpackage

FILE: design/pts_if.sv
// Handshake interfaces for the request and result channels.
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [23:0] frequency_hz;

    modport source (output valid, output command, output frequency_hz, input ready);
    modport sink (input valid, input command, input frequency_hz, output ready);
endinterface

interface pts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  prescaler_index;
    logic [15:0] top_value;
    logic [14:0] compare_value;
    logic        compare_written;
    logic        counter_restart;

    modport source (output valid, output status, output prescaler_index, output top_value,
                    output compare_value, output compare_written, output counter_restart,
                    input ready);
    modport sink (input valid, input status, input prescaler_index, input top_value,
                  input compare_value, input compare_written, input counter_restart,
                  output ready);
endinterface

FILE: design/pts_datapath.sv
// Datapath: request latch, bit-serial divider, prescaler search and timer state.
module pts_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pts_pkg::t_dp_cmd i_cmd,
    input  logic             i_command,
    input  logic [23:0]      i_frequency_hz,
    output pts_pkg::t_result o_result
);
    import pts_pkg::*;

    logic        r_cmd;
    logic [23:0] r_freq;
    logic [23:0] r_dvd;
    logic [23:0] r_rem;
    logic [23:0] r_quo;
    logic        r_enabled, n_enabled;
    logic [2:0]  r_presc, n_presc;
    logic [15:0] r_top, n_top;
    t_result     r_result, n_result;

    logic [24:0] rem_sh;
    logic [24:0] rem_diff;
    logic        q_bit;

    // One quotient bit per step: restoring division of the clock rate by f.
    always_comb begin
        rem_sh   = {r_rem, r_dvd[23]};
        rem_diff = rem_sh - {1'b0, r_freq};
        q_bit    = (rem_sh >= {1'b0, r_freq});
    end

    logic [2:0]  sel_idx;
    logic [15:0] sel_top;
    logic        sel_same;
    logic        keep_fit;
    logic [15:0] keep_top;

    // Quotient of clock / f shifted per prescaler equals clock / (p * f).
    always_comb begin
        logic [23:0] q_n;
        logic [23:0] q_m1;
        logic [23:0] q_cur;
        logic [23:0] q_cur_m1;
        logic        found;
        sel_idx = PRESC_LAST;
        sel_top = TOP_MAX;
        found   = 1'b0;
        for (int n = 0; n < PRESC_COUNT; n++) begin
            q_n  = r_quo >> presc_shift(3'(n));
            q_m1 = q_n - 24'd1;
            if (!found && q_n != '0 && q_n <= FIT_MAX) begin
                found   = 1'b1;
                sel_idx = 3'(n);
                sel_top = q_m1[15:0];
            end
        end
        sel_same = r_enabled && sel_idx == r_presc && sel_top == r_top;
        // Kept prescaler needs q >= 2 (f at most half the scaled clock) and top in range.
        q_cur    = r_quo >> presc_shift(r_presc);
        q_cur_m1 = q_cur - 24'd1;
        keep_fit = q_cur >= 24'd2 && q_cur <= FIT_MAX;
        keep_top = q_cur_m1[15:0];
    end

    always_comb begin
        logic     f_bad;
        logic     cw;
        logic     rs;
        t_status  st;
        n_enabled = r_enabled;
        n_presc   = r_presc;
        n_top     = r_top;
        cw        = 1'b0;
        rs        = 1'b0;
        f_bad     = r_freq == '0 || r_freq > CLOCK_HZ;
        if (r_cmd == CMD_RETUNE && !r_enabled) begin
            st = ST_DISABLED;
        end else if (f_bad) begin
            st = ST_RANGE;
        end else if (r_cmd == CMD_RETUNE && keep_fit) begin
            st    = ST_APPLIED;
            n_top = keep_top;
            rs    = 1'b1;
            cw    = 1'b1;
        end else begin
            cw = r_cmd == CMD_RETUNE;
            if (sel_same) begin
                st = ST_UNCHANGED;
            end else begin
                st        = ST_APPLIED;
                n_enabled = 1'b1;
                n_presc   = sel_idx;
                n_top     = sel_top;
                rs        = 1'b1;
            end
        end
        n_result.status          = st;
        n_result.prescaler_index = n_presc;
        n_result.top_value       = n_top;
        n_result.compare_value   = n_top[15:1];
        n_result.compare_written = cw;
        n_result.counter_restart = rs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_presc   <= '0;
            r_top     <= '0;
        end else if (i_cmd.commit) begin
            r_enabled <= n_enabled;
            r_presc   <= n_presc;
            r_top     <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_freq <= i_frequency_hz;
            r_dvd  <= CLOCK_HZ;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[22:0], 1'b0};
            r_quo <= {r_quo[22:0], q_bit};
            if (q_bit) begin
                r_rem <= rem_diff[23:0];
            end else begin
                r_rem <= rem_sh[23:0];
            end
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

FILE: design/pts_controller.sv
// Controller: sequences accept, division steps and result hand-off.
module pts_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output pts_pkg::t_dp_cmd o_cmd
);
    import pts_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int unsigned CNT_W = $clog2(DIV_STEPS);

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Hold the result until the output register is free.
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/pwm_timer_prescaler_select.sv
// Top level of the PWM prescaler select block.
//
// Converts a requested PWM frequency into timer settings for a 16 MHz clock.
// Command 0 (enable) picks the smallest prescaler of 1, 8, 64, 256, 1024 whose
// top value 16000000 / (prescaler * f) - 1 fits in 16 bits; if none fits,
// prescaler 1024 with top 65535 is used. If the block was already enabled and
// the selection equals the stored setting, status reports unchanged and the
// counter is not restarted. Command 1 (retune) is rejected while disabled;
// otherwise it keeps the current prescaler when f is in range for it, else
// reselects, and always writes compare = top / 2. A frequency of zero or above
// 16 MHz returns status out of range with no change. Each request yields one
// result transaction carrying the setting in use afterwards.
// Sequence: the operands are latched when the request is accepted, then the
// bit-serial divider produces one quotient bit of 16000000 / f per cycle, and
// a final state selects and commits the result. The controller is back in
// idle the cycle after commit; a new request is not accepted before then, but
// it is accepted even while the previous result is still waiting in the output
// register; the commit stalls only if that result has not been taken by then.
module pwm_timer_prescaler_select (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pts_in_if.sink   i_in,
    pts_out_if.source o_out
);
    import pts_pkg::*;

    t_dp_cmd dp_cmd;
    t_result dp_result;
    logic    in_ready;
    logic    out_valid;

    // Sequence the request through the divider and into the output register.
    pts_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (dp_cmd)
    );

    // Divide, search the prescaler table and update the stored timer setting.
    pts_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_command      (i_in.command),
        .i_frequency_hz (i_in.frequency_hz),
        .o_result       (dp_result)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.status          = dp_result.status;
    assign o_out.prescaler_index = dp_result.prescaler_index;
    assign o_out.top_value       = dp_result.top_value;
    assign o_out.compare_value   = dp_result.compare_value;
    assign o_out.compare_written = dp_result.compare_written;
    assign o_out.counter_restart = dp_result.counter_restart;

endmodule

FILE: design/pts_checker.sv
// Port-level checker for the PWM prescaler select block, with its bind.
`include "pwm_timer_prescaler_select_assert.svh"

module pts_sva_checker (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pts_out_if.source i_out
);
    import pts_pkg::*;

    // Hold a stalled result transaction.
    `PTS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out.valid && !i_out.ready, i_out.valid && $stable(i_out.top_value) && $stable(i_out.status))

    // Compare always mirrors half of the top value.
    `PTS_ASSERT_IMP(a_cmp_half, i_clk, i_rst_n, i_out.valid, i_out.compare_value == i_out.top_value[15:1])

    // Rejected requests write nothing and do not restart the counter.
    `PTS_ASSERT_IMP(a_reject_quiet, i_clk, i_rst_n, i_out.valid && (i_out.status == ST_DISABLED || i_out.status == ST_RANGE), !i_out.compare_written && !i_out.counter_restart)

    // Restart only when a setting is applied.
    `PTS_ASSERT_IMP(a_restart_applied, i_clk, i_rst_n, i_out.valid && i_out.counter_restart, i_out.status == ST_APPLIED)

    // Prescaler index stays within the table.
    `PTS_ASSERT_IMP(a_presc_range, i_clk, i_rst_n, i_out.valid, i_out.prescaler_index <= PRESC_LAST)

endmodule

bind pwm_timer_prescaler_select pts_sva_checker u_pts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_out   (o_out)
);

FILE: dv/pts_checker.sv
// Result predictor and comparator for the PWM prescaler select block.
`timescale 1ns / 1ps

module pts_checker (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pts_in_if        i_req,
    pts_out_if       i_res,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_checked,
    output int       o_applied,
    output int       o_unchanged,
    output int       o_flagged
);
    import pts_pkg::*;

    localparam longint unsigned TIMER_CLK_HZ = 64'd16000000;
    localparam longint unsigned TOP_LIMIT    = 64'd65535;
    localparam longint unsigned DIVIDERS [5] = '{1, 8, 64, 256, 1024};

    // Timer setting as the block should hold it.
    logic        tmr_enabled;
    logic [2:0]  tmr_presc;
    logic [15:0] tmr_top;

    t_result     setting_q [$];
    int          errors;
    int          checked;
    int          status_hits [4];

    assign o_fail_count = errors;
    assign o_pending    = setting_q.size();
    assign o_checked    = checked;
    assign o_applied    = status_hits[ST_APPLIED];
    assign o_unchanged  = status_hits[ST_UNCHANGED];
    assign o_flagged    = status_hits[ST_DISABLED] + status_hits[ST_RANGE];

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("ERROR at %0t: result %0d %s got 0x%0h expected 0x%0h",
                 $realtime, checked, what, got, want);
    endtask

    // Smallest prescaler whose top fits 16 bits; 1024 with full top if none does.
    function automatic t_status pick_prescaler(input longint unsigned f, output logic restart);
        logic [2:0]       idx;
        longint unsigned  top;
        longint unsigned  q;
        idx = 3'd4;
        top = TOP_LIMIT;
        for (int n = 0; n < 5; n++) begin
            q = TIMER_CLK_HZ / (DIVIDERS[n] * f);
            if (q >= 1 && q - 1 <= TOP_LIMIT) begin
                idx = 3'(n);
                top = q - 1;
                break;
            end
        end
        if (tmr_enabled && idx == tmr_presc && 16'(top) == tmr_top) begin
            restart = 1'b0;
            return ST_UNCHANGED;
        end
        tmr_enabled = 1'b1;
        tmr_presc   = idx;
        tmr_top     = 16'(top);
        restart     = 1'b1;
        return ST_APPLIED;
    endfunction

    function automatic t_result predict_setting(input logic cmd, input logic [23:0] freq);
        t_result          r;
        t_status          st;
        logic             restart;
        logic             written;
        longint unsigned  f;
        longint unsigned  p;
        longint unsigned  q;
        longint unsigned  hi;
        f       = 64'(freq);
        restart = 1'b0;
        written = 1'b0;
        if (cmd == CMD_RETUNE && !tmr_enabled) begin
            st = ST_DISABLED;
        end else if (f == 0 || f > TIMER_CLK_HZ) begin
            st = ST_RANGE;
        end else if (cmd == CMD_ENABLE) begin
            st = pick_prescaler(f, restart);
        end else begin
            p  = DIVIDERS[(tmr_presc > 3'd4) ? 4 : tmr_presc];
            hi = TIMER_CLK_HZ / (2 * p);
            q  = TIMER_CLK_HZ / (p * f);
            if (f <= hi && q >= 1 && q - 1 <= TOP_LIMIT) begin
                tmr_top = 16'(q - 1);
                restart = 1'b1;
                st      = ST_APPLIED;
            end else begin
                st = pick_prescaler(f, restart);
            end
            written = 1'b1;
        end
        r.status          = st;
        r.prescaler_index = tmr_presc;
        r.top_value       = tmr_top;
        r.compare_value   = tmr_top[15:1];
        r.compare_written = written;
        r.counter_restart = restart;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tmr_enabled = 1'b0;
            tmr_presc   = 3'd0;
            tmr_top     = 16'd0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (setting_q.size() == 0) begin
                    report_mismatch("unexpected result, status", i_res.status, 0);
                end else begin
                    want = setting_q.pop_front();
                    if (i_res.status !== want.status)
                        report_mismatch("status", i_res.status, want.status);
                    if (i_res.prescaler_index !== want.prescaler_index)
                        report_mismatch("prescaler_index", i_res.prescaler_index,
                                        want.prescaler_index);
                    if (i_res.top_value !== want.top_value)
                        report_mismatch("top_value", i_res.top_value, want.top_value);
                    if (i_res.compare_value !== want.compare_value)
                        report_mismatch("compare_value", i_res.compare_value,
                                        want.compare_value);
                    if (i_res.compare_written !== want.compare_written)
                        report_mismatch("compare_written", i_res.compare_written,
                                        want.compare_written);
                    if (i_res.counter_restart !== want.counter_restart)
                        report_mismatch("counter_restart", i_res.counter_restart,
                                        want.counter_restart);
                    status_hits[want.status]++;
                end
                checked++;
            end
            if (i_req.valid && i_req.ready)
                setting_q.push_back(predict_setting(i_req.command, i_req.frequency_hz));
        end
    end

endmodule

FILE: dv/pwm_timer_prescaler_select_tb.sv
// Stimulus, clocking and verdict for the PWM prescaler select testbench.
`timescale 1ns / 1ps

module pwm_timer_prescaler_select_tb;
    import pts_pkg::*;

    localparam int RANDOM_REQUESTS = 1800;
    localparam int STALL_CYCLES    = 250;
    localparam int DRAIN_CYCLES    = 60;

    // Prescaler thresholds and retune range edges, with their neighbors.
    localparam logic [23:0] EDGE_FREQS [18] = '{
        24'd3, 24'd4, 24'd30, 24'd31, 24'd244, 24'd245,
        24'd7812, 24'd7813, 24'd31250, 24'd31251, 24'd125000, 24'd125001,
        24'd1000000, 24'd1000001, 24'd8000000, 24'd8000001,
        24'd16000000, 24'd16000001
    };

    logic i_clk;
    logic i_rst_n;

    pts_in_if  req_if ();
    pts_out_if res_if ();

    int  fail_count;
    int  pending;
    int  checked;
    int  applied;
    int  unchanged;
    int  flagged;
    int  sent;
    bit  gaps_on;
    bit  hold_results;

    pwm_timer_prescaler_select u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    pts_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_applied    (applied),
        .o_unchanged  (unchanged),
        .o_flagged    (flagged)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run well past the slowest legal completion.
    initial begin
        #5_000_000;
        $display("pwm_timer_prescaler_select: mismatch");
        $finish;
    end

    // Result side: take results with random back-pressure; on request, hold
    // off for a long stretch so the block backs up into its request port.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_if.ready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end else begin
                res_if.ready <= !gaps_on || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // Offer one request transaction; insert random gaps first, then hold the
    // payload until the block takes it.
    task automatic send_req(input logic cmd, input logic [23:0] freq);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.frequency_hz <= freq;
        do @(posedge i_clk); while (!req_if.ready);
        sent++;
    endtask

    // Random request frequency, weighted toward legal values that drive the
    // selection through every prescaler and toward repeats that come back
    // unchanged.
    function automatic logic [23:0] pick_freq(input logic [23:0] last_freq);
        int unsigned pick;
        int unsigned sh;
        int          f;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            f = ($urandom_range(0, 3) == 0) ? 0 : 16000001 + $urandom_range(0, 777214);
        end else if (pick < 35) begin
            f = $urandom_range(1, 2000);
        end else if (pick < 55) begin
            f = int'(EDGE_FREQS[$urandom_range(0, 17)]) + $urandom_range(0, 4) - 2;
        end else if (pick < 70) begin
            f = last_freq;
        end else begin
            sh = $urandom_range(1, 24);
            f  = $urandom_range(1, (1 << sh) - 1);
        end
        return 24'(f);
    endfunction

    initial begin
        logic [23:0] freq;
        logic [23:0] last_freq;
        logic        cmd;

        // Drive every input to a known value before reset.
        req_if.valid        = 1'b0;
        req_if.command      = CMD_ENABLE;
        req_if.frequency_hz = 24'd0;
        gaps_on             = 1'b1;
        hold_results        = 1'b0;
        sent                = 0;
        i_rst_n             = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: rejection while disabled comes before the range check.
        send_req(CMD_RETUNE, 24'd1000);
        send_req(CMD_RETUNE, 24'd0);
        send_req(CMD_ENABLE, 24'd0);
        send_req(CMD_ENABLE, 24'd16000001);
        send_req(CMD_ENABLE, 24'hFFFFFF);
        // Fastest legal rate, then the same again to report unchanged.
        send_req(CMD_ENABLE, 24'd16000000);
        send_req(CMD_ENABLE, 24'd16000000);
        // Prescaler boundaries.
        send_req(CMD_ENABLE, 24'd244);
        send_req(CMD_ENABLE, 24'd245);
        send_req(CMD_ENABLE, 24'd30);
        send_req(CMD_ENABLE, 24'd3);
        send_req(CMD_ENABLE, 24'd1);
        // Retune inside the range of the kept prescaler, then outside it.
        send_req(CMD_RETUNE, 24'd2);
        send_req(CMD_RETUNE, 24'd40000);
        // Reselect on retune landing on the stored setting: compare still written.
        send_req(CMD_RETUNE, 24'd9000000);
        send_req(CMD_RETUNE, 24'd9000000);
        send_req(CMD_RETUNE, 24'd0);
        send_req(CMD_RETUNE, 24'hFFFFFF);
        send_req(CMD_RETUNE, 24'd16000000);
        send_req(CMD_RETUNE, 24'd8000000);
        send_req(CMD_RETUNE, 24'd8000001);
        send_req(CMD_ENABLE, 24'd100);
        send_req(CMD_RETUNE, 24'd100);
        send_req(CMD_RETUNE, 24'd7813);

        // Random requests: mostly legal, with a quiet stretch and one long
        // result-side hold-off while requests keep coming.
        last_freq = 24'd100;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i == 300)
                hold_results = 1'b1;
            gaps_on = !(i >= 1000 && i < 1300);
            cmd     = ($urandom_range(0, 99) < 60) ? CMD_RETUNE : CMD_ENABLE;
            freq    = pick_freq(last_freq);
            send_req(cmd, freq);
            last_freq = freq;
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        gaps_on = 1'b1;

        // Drain outstanding results, then watch for anything extra.
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results.", sent, checked);
        $display("Outcomes: %0d applied, %0d unchanged, %0d rejected or out of range.",
                 applied, unchanged, flagged);
        if (fail_count == 0 && pending == 0) begin
            $display("pwm_timer_prescaler_select: match");
        end else begin
            $display("pwm_timer_prescaler_select: mismatch");
        end
        $finish;
    end

endmodule
